// ----- rtl/cbp_pkg.sv -----
// Shared constants and the arctangent table for the Compton cone test pipeline.
// No dependencies; used by cbp_angle, the top level and the testbench.
`default_nettype none
package cbp_pkg;

    localparam int SQ_W         = 62;
    localparam int ISQ_STEPS    = 31;
    localparam int XW           = 33;
    localparam int NORM_LEN     = 31;
    localparam int CW           = 35;
    localparam int ZW           = 26;
    localparam int TAB_BITS     = 16;
    localparam int CORDIC_STEPS = 23;
    localparam int LANE_LAT     = ISQ_STEPS + CORDIC_STEPS + 3;
    localparam int MASS_KEV     = 511;
    localparam int HALF_TURN_DEG = 180;
    localparam int GEO_LIMIT    = 30;
    localparam int CMP_LIMIT    = 31;

    localparam logic [15:0] THRESHOLD_RESET = 16'd1280;
    localparam logic signed [ZW-1:0] DEG90  = ZW'((HALF_TURN_DEG / 2) * (2 ** TAB_BITS));
    localparam logic signed [ZW-1:0] DEG180 = ZW'(HALF_TURN_DEG * (2 ** TAB_BITS));

    function automatic logic signed [ZW-1:0] atan_tab(input int i);
        logic signed [ZW-1:0] t;
        case (i)
            0:  t = ZW'(2949120);
            1:  t = ZW'(1740967);
            2:  t = ZW'(919879);
            3:  t = ZW'(466945);
            4:  t = ZW'(234379);
            5:  t = ZW'(117304);
            6:  t = ZW'(58666);
            7:  t = ZW'(29335);
            8:  t = ZW'(14668);
            9:  t = ZW'(7334);
            10: t = ZW'(3667);
            11: t = ZW'(1833);
            12: t = ZW'(917);
            13: t = ZW'(458);
            14: t = ZW'(229);
            15: t = ZW'(115);
            16: t = ZW'(57);
            17: t = ZW'(29);
            18: t = ZW'(14);
            19: t = ZW'(7);
            20: t = ZW'(4);
            21: t = ZW'(2);
            22: t = ZW'(1);
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/cbp_angle.sv -----
// Angle lane: pipelined integer square root, normalization and CORDIC arctangent.
// Depends on cbp_pkg; instantiated twice by the top level.
`default_nettype none
module cbp_angle #(
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  wire logic                              aclk,
    input  wire logic                              adv,
    input  wire logic [cbp_pkg::SQ_W-1:0]          sq_in,
    input  wire logic signed [cbp_pkg::XW-1:0]     x_in,
    input  wire logic                              dbl_in,
    output logic [ANGLE_FRAC_BITS+7:0]             angle_out
);

    localparam int SW    = cbp_pkg::SQ_W;
    localparam int N     = cbp_pkg::ISQ_STEPS;
    localparam int XW    = cbp_pkg::XW;
    localparam int CW    = cbp_pkg::CW;
    localparam int ZW    = cbp_pkg::ZW;
    localparam int NC    = cbp_pkg::CORDIC_STEPS;
    localparam int ANG_W = ANGLE_FRAC_BITS + 8;
    localparam int RND   = cbp_pkg::TAB_BITS - ANGLE_FRAC_BITS;
    localparam int LEN_W = $clog2(XW + 1);

    logic [SW-1:0]        n_reg   [1:N];
    logic [SW-1:0]        r_reg   [1:N];
    logic signed [XW-1:0] x_reg   [1:N];
    logic                 dbl_reg [1:N];

    genvar k;
    generate
        for (k = 1; k <= N; k++) begin : g_sq
            localparam logic [SW-1:0] BIT = SW'(1) << (2 * (N - k));
            logic [SW-1:0]        n_prev;
            logic [SW-1:0]        r_prev;
            logic [SW-1:0]        trial;
            logic signed [XW-1:0] x_prev;
            logic                 dbl_prev;
            if (k == 1) begin : g_first
                assign n_prev   = sq_in;
                assign r_prev   = '0;
                assign x_prev   = x_in;
                assign dbl_prev = dbl_in;
            end else begin : g_next
                assign n_prev   = n_reg[k-1];
                assign r_prev   = r_reg[k-1];
                assign x_prev   = x_reg[k-1];
                assign dbl_prev = dbl_reg[k-1];
            end
            assign trial = r_prev + BIT;
            always_ff @(posedge aclk) begin
                if (adv) begin
                    if (n_prev >= trial) begin
                        n_reg[k] <= n_prev - trial;
                        r_reg[k] <= (r_prev >> 1) + BIT;
                    end else begin
                        n_reg[k] <= n_prev;
                        r_reg[k] <= r_prev >> 1;
                    end
                    x_reg[k]   <= x_prev;
                    dbl_reg[k] <= dbl_prev;
                end
            end
        end
    endgenerate

    logic [XW-1:0]    y_root;
    logic [XW-1:0]    x_mag;
    logic [XW-1:0]    m_max;
    logic [LEN_W-1:0] m_len;

    always_comb begin
        y_root = dbl_reg[N] ? XW'({r_reg[N][30:0], 1'b0}) : XW'(r_reg[N][30:0]);
        x_mag  = x_reg[N][XW-1] ? XW'(-x_reg[N]) : XW'(x_reg[N]);
        m_max  = (x_mag > y_root) ? x_mag : y_root;
        m_len  = '0;
        for (int i = 0; i < XW; i++) begin
            if (m_max[i]) begin
                m_len = LEN_W'(i + 1);
            end
        end
    end

    logic [XW-1:0]    xmag_reg;
    logic             xneg_reg;
    logic [XW-1:0]    ynorm_reg;
    logic [LEN_W-1:0] len_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            xmag_reg  <= x_mag;
            xneg_reg  <= x_reg[N][XW-1];
            ynorm_reg <= y_root;
            len_reg   <= m_len;
        end
    end

    logic signed [CW-1:0] cx_reg   [0:NC];
    logic signed [CW-1:0] cy_reg   [0:NC];
    logic signed [ZW-1:0] cz_reg   [0:NC];
    logic                 zero_reg [0:NC];

    logic [LEN_W-1:0] sh;
    logic [XW-1:0]    xs;
    logic [XW-1:0]    ys;
    logic             rot;

    always_comb begin
        if (len_reg < LEN_W'(cbp_pkg::NORM_LEN)) begin
            sh = LEN_W'(cbp_pkg::NORM_LEN) - len_reg;
            xs = XW'(xmag_reg << sh);
            ys = XW'(ynorm_reg << sh);
        end else begin
            sh = len_reg - LEN_W'(cbp_pkg::NORM_LEN);
            xs = xmag_reg >> sh;
            ys = ynorm_reg >> sh;
        end
        rot = xneg_reg && (xs != '0);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            zero_reg[0] <= (len_reg == '0);
            if (rot) begin
                cx_reg[0] <= CW'(ys);
                cy_reg[0] <= CW'(xs);
                cz_reg[0] <= cbp_pkg::DEG90;
            end else begin
                cx_reg[0] <= CW'(xs);
                cy_reg[0] <= CW'(ys);
                cz_reg[0] <= '0;
            end
        end
    end

    genvar i;
    generate
        for (i = 0; i < NC; i++) begin : g_cordic
            localparam logic signed [ZW-1:0] ANG = cbp_pkg::atan_tab(i);
            logic signed [CW-1:0] yneg;
            logic signed [CW-1:0] dx;
            logic signed [CW-1:0] dy;
            assign yneg = -cy_reg[i];
            assign dx   = cy_reg[i][CW-1] ? -(yneg >>> i) : (cy_reg[i] >>> i);
            assign dy   = cx_reg[i] >>> i;
            always_ff @(posedge aclk) begin
                if (adv) begin
                    zero_reg[i+1] <= zero_reg[i];
                    if (!cy_reg[i][CW-1]) begin
                        cx_reg[i+1] <= cx_reg[i] + dx;
                        cy_reg[i+1] <= cy_reg[i] - dy;
                        cz_reg[i+1] <= cz_reg[i] + ANG;
                    end else begin
                        cx_reg[i+1] <= cx_reg[i] - dx;
                        cy_reg[i+1] <= cy_reg[i] + dy;
                        cz_reg[i+1] <= cz_reg[i] - ANG;
                    end
                end
            end
        end
    endgenerate

    logic signed [ZW-1:0] z_clamp;
    logic [ZW-1:0]        z_round;
    logic [ANG_W-1:0]     angle_reg;

    always_comb begin
        if (zero_reg[NC] || cz_reg[NC][ZW-1]) begin
            z_clamp = '0;
        end else if (cz_reg[NC] > cbp_pkg::DEG180) begin
            z_clamp = cbp_pkg::DEG180;
        end else begin
            z_clamp = cz_reg[NC];
        end
        z_round = ZW'(z_clamp) + ZW'(1 << (RND - 1));
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            angle_reg <= ANG_W'(z_round >> RND);
        end
    end

    assign angle_out = angle_reg;

endmodule
`default_nettype wire

// ----- rtl/compton_cone_backprojection_test_top.sv -----
// Top level of the Compton cone test: input unpack, vector and energy arithmetic,
// two angle lanes and the threshold compare. Depends on cbp_pkg and cbp_angle.
//
// Usage:
//   s_tdata carries one event plus one image point per item; m_tdata returns
//   hit and kinematics_valid for that item, in the same order.
//   cfg_we/cfg_wdata write angle_threshold (1/2^ANGLE_FRAC_BITS degree);
//   write it only while no items are in flight.
// Pipeline: 7 arithmetic stages, then 57 stages in each angle lane (31 square-root
//   steps, 2 normalize steps, 23 CORDIC steps and rounding), then the
//   compare/output register that drives m_tvalid.
// Throughput: one item per cycle while not stalled; every stage is a register,
//   the square root and CORDIC loops are unrolled one step per stage.
// Reset: aresetn low for one edge empties the pipeline and loads the
//   threshold with 1280; no clearing pass is needed.
// Stall: while m_tvalid is high and m_tready low, the whole pipeline holds
//   and s_tready is low; nothing is dropped or repeated.
`default_nettype none
module compton_cone_backprojection_test_top #(
    parameter int ENERGY_BITS     = 12,
    parameter int COORD_BITS      = 16,
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [15:0]          cfg_wdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // scatter_x, scatter_y, scatter_z, scatter_energy, absorber_x, absorber_y,
    // absorber_z, absorber_energy, point_x, point_y, point_z
    input  wire logic [((9*COORD_BITS+2*ENERGY_BITS+7)/8)*8-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // hit, kinematics_valid
    output logic [7:0]                m_tdata
);

    localparam int CB    = COORD_BITS;
    localparam int EB    = ENERGY_BITS;
    localparam int UW    = CB + 1;
    localparam int PW    = 2 * UW;
    localparam int GM    = PW + 2;
    localparam int GX    = (GM > cbp_pkg::GEO_LIMIT) ? GM : cbp_pkg::GEO_LIMIT;
    localparam int GLW   = $clog2(GM + 1);
    localparam int AW    = EB + 9;
    localparam int EW    = EB + 1;
    localparam int DW    = 2 * EB + 1;
    localparam int BW    = 2 * EB + 3;
    localparam int CM    = 2 * EB + 2;
    localparam int CX    = (CM > cbp_pkg::CMP_LIMIT) ? CM : cbp_pkg::CMP_LIMIT;
    localparam int CLW   = $clog2(CM + 1);
    localparam int XW    = cbp_pkg::XW;
    localparam int SW    = cbp_pkg::SQ_W;
    localparam int LAT   = cbp_pkg::LANE_LAT;
    localparam int ANG_W = ANGLE_FRAC_BITS + 8;
    localparam int CMP_W = (ANG_W > 16) ? ANG_W : 16;

    localparam int OFF_SX = 0;
    localparam int OFF_SY = CB;
    localparam int OFF_SZ = 2 * CB;
    localparam int OFF_ES = 3 * CB;
    localparam int OFF_AX = 3 * CB + EB;
    localparam int OFF_AY = 4 * CB + EB;
    localparam int OFF_AZ = 5 * CB + EB;
    localparam int OFF_EA = 6 * CB + EB;
    localparam int OFF_PX = 6 * CB + 2 * EB;
    localparam int OFF_PY = 7 * CB + 2 * EB;
    localparam int OFF_PZ = 8 * CB + 2 * EB;

    typedef struct packed {
        logic vld;
        logic kv;
        logic len_ok;
    } side_t;

    logic adv;
    logic m_tvalid_reg;
    logic hit_reg;
    logic kv_out_reg;
    logic [15:0] thr_reg;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= cbp_pkg::THRESHOLD_RESET;
        end else if (cfg_we) begin
            thr_reg <= cfg_wdata;
        end
    end

    // stage 1: differences and energy terms
    logic signed [CB-1:0] sx, sy, sz, ax, ay, az, px, py, pz;
    logic [EB-1:0] es, ea;

    assign sx = s_tdata[OFF_SX +: CB];
    assign sy = s_tdata[OFF_SY +: CB];
    assign sz = s_tdata[OFF_SZ +: CB];
    assign ax = s_tdata[OFF_AX +: CB];
    assign ay = s_tdata[OFF_AY +: CB];
    assign az = s_tdata[OFF_AZ +: CB];
    assign px = s_tdata[OFF_PX +: CB];
    assign py = s_tdata[OFF_PY +: CB];
    assign pz = s_tdata[OFF_PZ +: CB];
    assign es = s_tdata[OFF_ES +: EB];
    assign ea = s_tdata[OFF_EA +: EB];

    logic                 vld1_reg;
    logic signed [UW-1:0] ux1_reg, uy1_reg, uz1_reg, vx1_reg, vy1_reg, vz1_reg;
    logic [AW-1:0]        a1_reg;
    logic [EB-1:0]        ea1_reg;
    logic [EW-1:0]        esum1_reg;
    logic                 esnz1_reg, eanz1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
        end else if (adv) begin
            vld1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ux1_reg   <= UW'(sx) - UW'(px);
            uy1_reg   <= UW'(sy) - UW'(py);
            uz1_reg   <= UW'(sz) - UW'(pz);
            vx1_reg   <= UW'(ax) - UW'(sx);
            vy1_reg   <= UW'(ay) - UW'(sy);
            vz1_reg   <= UW'(az) - UW'(sz);
            a1_reg    <= AW'(es) * AW'(cbp_pkg::MASS_KEV);
            ea1_reg   <= ea;
            esum1_reg <= EW'(es) + EW'(ea);
            esnz1_reg <= (es != '0);
            eanz1_reg <= (ea != '0);
        end
    end

    // stage 2: products
    logic                 vld2_reg;
    logic signed [PW-1:0] pyz2_reg, pzy2_reg, pzx2_reg, pxz2_reg, pxy2_reg, pyx2_reg;
    logic signed [PW-1:0] dxx2_reg, dyy2_reg, dzz2_reg;
    logic [DW-1:0]        d2_reg;
    logic [AW-1:0]        a2_reg;
    logic                 esnz2_reg, eanz2_reg, len2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld2_reg <= 1'b0;
        end else if (adv) begin
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pyz2_reg  <= PW'(uy1_reg) * PW'(vz1_reg);
            pzy2_reg  <= PW'(uz1_reg) * PW'(vy1_reg);
            pzx2_reg  <= PW'(uz1_reg) * PW'(vx1_reg);
            pxz2_reg  <= PW'(ux1_reg) * PW'(vz1_reg);
            pxy2_reg  <= PW'(ux1_reg) * PW'(vy1_reg);
            pyx2_reg  <= PW'(uy1_reg) * PW'(vx1_reg);
            dxx2_reg  <= PW'(ux1_reg) * PW'(vx1_reg);
            dyy2_reg  <= PW'(uy1_reg) * PW'(vy1_reg);
            dzz2_reg  <= PW'(uz1_reg) * PW'(vz1_reg);
            d2_reg    <= DW'(ea1_reg) * DW'(esum1_reg);
            a2_reg    <= a1_reg;
            esnz2_reg <= esnz1_reg;
            eanz2_reg <= eanz1_reg;
            len2_reg  <= ((ux1_reg != '0) || (uy1_reg != '0) || (uz1_reg != '0))
                      && ((vx1_reg != '0) || (vy1_reg != '0) || (vz1_reg != '0));
        end
    end

    // stage 3: cross, dot, b
    logic                   vld3_reg;
    logic signed [PW:0]     cx3_reg, cy3_reg, cz3_reg;
    logic signed [PW+1:0]   dot3_reg;
    logic signed [BW-1:0]   b_next;
    logic [BW-1:0]          b3_reg;
    logic [AW-1:0]          a3_reg;
    logic                   kv3_reg, len3_reg;

    assign b_next = $signed({1'b0, d2_reg, 1'b0}) - $signed(BW'(a2_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld3_reg <= 1'b0;
        end else if (adv) begin
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cx3_reg  <= (PW+1)'(pyz2_reg) - (PW+1)'(pzy2_reg);
            cy3_reg  <= (PW+1)'(pzx2_reg) - (PW+1)'(pxz2_reg);
            cz3_reg  <= (PW+1)'(pxy2_reg) - (PW+1)'(pyx2_reg);
            dot3_reg <= (PW+2)'(dxx2_reg) + (PW+2)'(dyy2_reg) + (PW+2)'(dzz2_reg);
            b3_reg   <= b_next;
            a3_reg   <= a2_reg;
            kv3_reg  <= esnz2_reg && eanz2_reg && !b_next[BW-1] && (b_next != '0);
            len3_reg <= len2_reg;
        end
    end

    // stage 4: magnitudes and normalizing shift counts
    logic [GM-1:0]  gmag [0:3];
    logic [GM-1:0]  gmax;
    logic [GLW-1:0] glen;
    logic [GLW-1:0] gsh;
    logic [CM-1:0]  aa, bb, cmax;
    logic [CLW-1:0] clen;
    logic [CLW-1:0] csh;

    always_comb begin
        gmag[0] = cx3_reg[PW]    ? GM'(-cx3_reg)  : GM'(cx3_reg);
        gmag[1] = cy3_reg[PW]    ? GM'(-cy3_reg)  : GM'(cy3_reg);
        gmag[2] = cz3_reg[PW]    ? GM'(-cz3_reg)  : GM'(cz3_reg);
        gmag[3] = dot3_reg[PW+1] ? GM'(-dot3_reg) : GM'(dot3_reg);
        gmax = gmag[0];
        for (int i = 1; i < 4; i++) begin
            if (gmag[i] > gmax) begin
                gmax = gmag[i];
            end
        end
        glen = '0;
        for (int i = 0; i < GM; i++) begin
            if (gmax[i]) begin
                glen = GLW'(i + 1);
            end
        end
        gsh = (glen > GLW'(cbp_pkg::GEO_LIMIT)) ? glen - GLW'(cbp_pkg::GEO_LIMIT) : '0;

        aa   = CM'(a3_reg);
        bb   = b3_reg[CM-1:0];
        cmax = (aa > bb) ? aa : bb;
        clen = '0;
        for (int i = 0; i < CM; i++) begin
            if (cmax[i]) begin
                clen = CLW'(i + 1);
            end
        end
        csh = (clen > CLW'(cbp_pkg::CMP_LIMIT)) ? clen - CLW'(cbp_pkg::CMP_LIMIT) : '0;
    end

    logic           vld4_reg;
    logic [GM-1:0]  gmag4_reg [0:3];
    logic           dneg4_reg;
    logic [GLW-1:0] gsh4_reg;
    logic [CM-1:0]  aa4_reg, bb4_reg;
    logic [CLW-1:0] csh4_reg;
    logic           kv4_reg, len4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld4_reg <= 1'b0;
        end else if (adv) begin
            vld4_reg <= vld3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 4; i++) begin
                gmag4_reg[i] <= gmag[i];
            end
            dneg4_reg <= dot3_reg[PW+1];
            gsh4_reg  <= gsh;
            aa4_reg   <= aa;
            bb4_reg   <= bb;
            csh4_reg  <= csh;
            kv4_reg   <= kv3_reg;
            len4_reg  <= len3_reg;
        end
    end

    // stage 5: apply shifts toward zero
    logic [GX-1:0] gshift [0:3];
    logic [CX-1:0] aa_sh, bb_sh;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            gshift[i] = GX'(gmag4_reg[i]) >> gsh4_reg;
        end
        aa_sh = CX'(aa4_reg) >> csh4_reg;
        bb_sh = CX'(bb4_reg) >> csh4_reg;
    end

    logic               vld5_reg;
    logic [29:0]        c5_reg [0:2];
    logic signed [30:0] dot5_reg;
    logic [30:0]        aa5_reg, bb5_reg;
    logic               kv5_reg, len5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld5_reg <= 1'b0;
        end else if (adv) begin
            vld5_reg <= vld4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                c5_reg[i] <= gshift[i][29:0];
            end
            dot5_reg <= dneg4_reg ? -$signed({1'b0, gshift[3][29:0]})
                                  : $signed({1'b0, gshift[3][29:0]});
            aa5_reg  <= aa_sh[30:0];
            bb5_reg  <= bb_sh[30:0];
            kv5_reg  <= kv4_reg;
            len5_reg <= len4_reg;
        end
    end

    // stage 6: squares and energy product
    logic               vld6_reg;
    logic [59:0]        sq6_reg [0:2];
    logic [SW-1:0]      prod6_reg;
    logic signed [31:0] xc6_reg;
    logic signed [30:0] dot6_reg;
    logic               kv6_reg, len6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld6_reg <= 1'b0;
        end else if (adv) begin
            vld6_reg <= vld5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                sq6_reg[i] <= 60'(c5_reg[i]) * 60'(c5_reg[i]);
            end
            prod6_reg <= SW'(aa5_reg) * SW'(bb5_reg);
            xc6_reg   <= $signed({1'b0, bb5_reg}) - $signed({1'b0, aa5_reg});
            dot6_reg  <= dot5_reg;
            kv6_reg   <= kv5_reg;
            len6_reg  <= len5_reg;
        end
    end

    // stage 7: sum of squares
    logic               vld7_reg;
    logic [SW-1:0]      sumsq7_reg;
    logic [SW-1:0]      prod7_reg;
    logic signed [31:0] xc7_reg;
    logic signed [30:0] dot7_reg;
    logic               kv7_reg, len7_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld7_reg <= 1'b0;
        end else if (adv) begin
            vld7_reg <= vld6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sumsq7_reg <= SW'(sq6_reg[0]) + SW'(sq6_reg[1]) + SW'(sq6_reg[2]);
            prod7_reg  <= prod6_reg;
            xc7_reg    <= xc6_reg;
            dot7_reg   <= dot6_reg;
            kv7_reg    <= kv6_reg;
            len7_reg   <= len6_reg;
        end
    end

    // angle lanes
    logic [ANG_W-1:0] geo_angle;
    logic [ANG_W-1:0] cmp_angle;

    cbp_angle #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_geo (
        .aclk      (aclk),
        .adv       (adv),
        .sq_in     (sumsq7_reg),
        .x_in      (XW'(dot7_reg)),
        .dbl_in    (1'b0),
        .angle_out (geo_angle)
    );

    cbp_angle #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_cmp (
        .aclk      (aclk),
        .adv       (adv),
        .sq_in     (prod7_reg),
        .x_in      (XW'(xc7_reg)),
        .dbl_in    (1'b1),
        .angle_out (cmp_angle)
    );

    side_t side_dly_reg [1:LAT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 1; i <= LAT; i++) begin
                side_dly_reg[i] <= '0;
            end
        end else if (adv) begin
            side_dly_reg[1] <= '{vld: vld7_reg, kv: kv7_reg, len_ok: len7_reg};
            for (int i = 2; i <= LAT; i++) begin
                side_dly_reg[i] <= side_dly_reg[i-1];
            end
        end
    end

    // compare and output register
    logic signed [ANG_W:0] ang_diff;
    logic [CMP_W-1:0]      diff_mag;

    always_comb begin
        ang_diff = $signed({1'b0, geo_angle}) - $signed({1'b0, cmp_angle});
        diff_mag = ang_diff[ANG_W] ? CMP_W'(-ang_diff) : CMP_W'(ang_diff);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= side_dly_reg[LAT].vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            kv_out_reg <= side_dly_reg[LAT].kv;
            hit_reg    <= side_dly_reg[LAT].kv && side_dly_reg[LAT].len_ok
                       && (diff_mag < CMP_W'(thr_reg));
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, kv_out_reg, hit_reg};

`ifndef NO_ASSERTIONS
    a_hit_needs_kin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && hit_reg |-> kv_out_reg)
        else $error("hit without valid kinematics");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> vld1_reg)
        else $error("accepted item missing from first stage");

    a_out_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        adv |=> m_tvalid_reg == $past(side_dly_reg[LAT].vld))
        else $error("output valid out of step with pipeline");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(vld7_reg) && $stable(side_dly_reg[LAT].vld))
        else $error("pipeline moved during stall");
`endif

endmodule
`default_nettype wire

// ----- verif/compton_cone_backprojection_test_top_test.sv -----
// Testbench for compton_cone_backprojection_test_top: directed table, then random events.
// Every result is checked against an in-bench predictor of the cone test.
// Depends on cbp_pkg and the RTL top level only.
`timescale 1ns / 100ps
module compton_cone_backprojection_test_top_test;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 80;
    localparam int HOLD_CYCLES    = 400;
    localparam int RANDOM_ITEMS   = 1800;

    typedef struct {
        logic signed [15:0] sx, sy, sz;
        logic [11:0]        es;
        logic signed [15:0] ax, ay, az;
        logic [11:0]        ea;
        logic signed [15:0] px, py, pz;
    } cone_event_t;

    typedef struct {
        logic hit;
        logic kin_ok;
    } cone_verdict_t;

    typedef struct {
        cone_event_t   ev;
        bit            known;
        cone_verdict_t want;
    } table_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_we = 1'b0;
    logic [15:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [167:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [7:0]   m_tdata;

    cone_verdict_t verdict_queue[$];
    logic [15:0]   threshold;
    int            mismatches = 0;
    bit            quiet = 1'b0;
    bit            hold_req = 1'b0;
    int            hold_count = 0;
    int            stuck_cycles = 0;

    compton_cone_backprojection_test_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #1 aclk = ~aclk;

    function automatic longint shr_tz(longint v, int s);
        if (v < 0) begin
            return -((-v) >>> s);
        end
        return v >>> s;
    endfunction

    function automatic longint unsigned sqrt_floor(longint unsigned n);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint angle_of(longint y, longint x);
        longint unsigned m;
        longint z = 0;
        longint t, dx, dy;
        m = (x < 0 ? -x : x);
        if (y > m) m = y;
        if (m == 0) return 0;
        while (m < (64'd1 << 30)) begin
            x = x * 2;
            y = y * 2;
            m <<= 1;
        end
        while (m >= (64'd1 << 31)) begin
            x = shr_tz(x, 1);
            y = shr_tz(y, 1);
            m >>= 1;
        end
        if (x < 0) begin
            t = x;
            x = y;
            y = -t;
            z = longint'(cbp_pkg::DEG90);
        end
        for (int i = 0; i < cbp_pkg::CORDIC_STEPS; i++) begin
            dx = shr_tz(y, i);
            dy = shr_tz(x, i);
            if (y >= 0) begin
                x += dx;
                y -= dy;
                z += longint'(cbp_pkg::atan_tab(i));
            end else begin
                x -= dx;
                y += dy;
                z -= longint'(cbp_pkg::atan_tab(i));
            end
        end
        if (z < 0) z = 0;
        if (z > longint'(cbp_pkg::DEG180)) z = longint'(cbp_pkg::DEG180);
        return (z + 128) >>> 8;
    endfunction

    function automatic cone_verdict_t predict_cone(cone_event_t e);
        cone_verdict_t res;
        longint es, ea, a, b, ux, uy, uz, vx, vy, vz, cx, cy, cz, dt, geo, cmp, diff;
        longint unsigned m, r, aa, bb;
        int s;
        es = longint'(e.es);
        ea = longint'(e.ea);
        a = cbp_pkg::MASS_KEV * es;
        b = 2 * ea * (es + ea) - a;
        res.kin_ok = es > 0 && ea > 0 && b > 0;
        res.hit = 1'b0;
        ux = longint'(e.sx) - longint'(e.px);
        uy = longint'(e.sy) - longint'(e.py);
        uz = longint'(e.sz) - longint'(e.pz);
        vx = longint'(e.ax) - longint'(e.sx);
        vy = longint'(e.ay) - longint'(e.sy);
        vz = longint'(e.az) - longint'(e.sz);
        if (res.kin_ok && (ux != 0 || uy != 0 || uz != 0) && (vx != 0 || vy != 0 || vz != 0))
        begin
            cx = uy * vz - uz * vy;
            cy = uz * vx - ux * vz;
            cz = ux * vy - uy * vx;
            dt = ux * vx + uy * vy + uz * vz;
            m = cx < 0 ? -cx : cx;
            if ((cy < 0 ? -cy : cy) > m) m = cy < 0 ? -cy : cy;
            if ((cz < 0 ? -cz : cz) > m) m = cz < 0 ? -cz : cz;
            if ((dt < 0 ? -dt : dt) > m) m = dt < 0 ? -dt : dt;
            s = 0;
            while ((m >> s) >= (64'd1 << 30)) s++;
            cx = shr_tz(cx, s);
            cy = shr_tz(cy, s);
            cz = shr_tz(cz, s);
            dt = shr_tz(dt, s);
            r = sqrt_floor(cx * cx + cy * cy + cz * cz);
            geo = angle_of(longint'(r), dt);
            aa = a;
            bb = b;
            m = aa > bb ? aa : bb;
            s = 0;
            while ((m >> s) >= (64'd1 << 31)) s++;
            aa >>= s;
            bb >>= s;
            cmp = angle_of(longint'(2 * sqrt_floor(aa * bb)), longint'(bb) - longint'(aa));
            diff = geo - cmp;
            if (diff < 0) diff = -diff;
            res.hit = diff < longint'(threshold);
        end
        return res;
    endfunction

    function automatic cone_event_t mk(int sx, int sy, int sz, int es, int ax, int ay,
                                       int az, int ea, int px, int py, int pz);
        cone_event_t e;
        e.sx = 16'(sx); e.sy = 16'(sy); e.sz = 16'(sz); e.es = 12'(es);
        e.ax = 16'(ax); e.ay = 16'(ay); e.az = 16'(az); e.ea = 12'(ea);
        e.px = 16'(px); e.py = 16'(py); e.pz = 16'(pz);
        return e;
    endfunction

    function automatic cone_event_t random_event(bit physical);
        cone_event_t e;
        e.sx = 16'($urandom); e.sy = 16'($urandom); e.sz = 16'($urandom);
        e.ax = 16'($urandom); e.ay = 16'($urandom); e.az = 16'($urandom);
        e.px = 16'($urandom); e.py = 16'($urandom); e.pz = 16'($urandom);
        e.es = 12'($urandom);
        e.ea = 12'($urandom);
        if (physical) begin
            e.es = 12'($urandom_range(1500, 1));
            e.ea = 12'($urandom_range(4095, 100));
            if ($urandom_range(9) == 0) begin
                e.px = e.sx; e.py = e.sy; e.pz = e.sz;
            end
        end
        return e;
    endfunction

    task automatic write_threshold(logic [15:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        threshold = v;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (verdict_queue.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic send_event(cone_event_t e, bit known, cone_verdict_t want);
        cone_verdict_t p;
        while (!quiet && $urandom_range(99) < 36) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {e.pz, e.py, e.px, e.ea, e.az, e.ay, e.ax, e.es, e.sz, e.sy, e.sx};
        do @(posedge aclk); while (!s_tready);
        p = predict_cone(e);
        if (known && (p.hit !== want.hit || p.kin_ok !== want.kin_ok))
            $error("table row disagrees with predictor: hit %0d/%0d kin %0d/%0d",
                   want.hit, p.hit, want.kin_ok, p.kin_ok);
        verdict_queue.push_back(p);
    endtask

    // receiver, checker and watchdog
    always @(posedge aclk) begin
        cone_verdict_t w;
        if (hold_req && hold_count < HOLD_CYCLES) begin
            hold_count <= hold_count + 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= quiet || ($urandom_range(99) >= 36);
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (verdict_queue.size() == 0) begin
                $error("result with no expectation waiting");
                mismatches++;
            end else begin
                w = verdict_queue.pop_front();
                if (m_tdata[0] !== w.hit) begin
                    $error("hit: expected %0d, got %0d", w.hit, m_tdata[0]);
                    mismatches++;
                end
                if (m_tdata[1] !== w.kin_ok) begin
                    $error("kinematics_valid: expected %0d, got %0d", w.kin_ok, m_tdata[1]);
                    mismatches++;
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (verdict_queue.size() == 0 && !s_tvalid)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        table_row_t    rows[$];
        cone_verdict_t none;
        cone_verdict_t no_hit;
        logic [15:0]   levels[4];
        none.hit = 1'b0;   none.kin_ok = 1'b0;
        no_hit.hit = 1'b0; no_hit.kin_ok = 1'b1;
        threshold = cbp_pkg::THRESHOLD_RESET;
        levels[0] = 16'd0;
        levels[1] = 16'd46080;
        levels[2] = 16'hFFFF;
        levels[3] = 16'd2560;

        // zero energies, backward cosine, zero-length vectors
        rows.push_back('{mk(10, 20, 30, 0, 500, 600, 700, 300, -100, -200, -300), 1, none});
        rows.push_back('{mk(10, 20, 30, 200, 500, 600, 700, 0, -100, -200, -300), 1, none});
        rows.push_back('{mk(10, 20, 30, 4095, 500, 600, 700, 1, -100, -200, -300), 1, none});
        rows.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, none});
        rows.push_back('{mk(10, 20, 30, 200, 500, 600, 700, 300, 10, 20, 30), 1, no_hit});
        rows.push_back('{mk(10, 20, 30, 200, 10, 20, 30, 300, -100, 20, 30), 1, no_hit});
        // parallel and antiparallel vectors
        rows.push_back('{mk(0, 0, 0, 200, 1000, 0, 0, 300, -1000, 0, 0), 0, none});
        rows.push_back('{mk(0, 0, 0, 200, 1000, 0, 0, 300, 1000, 0, 0), 0, none});
        rows.push_back('{mk(0, 0, 0, 4095, 0, 0, 100, 4095, 0, 0, -100), 0, none});
        // coordinate and energy extremes
        rows.push_back('{mk(32767, 32767, 32767, 4095, -32768, -32768, -32768, 4095,
                            -32768, 32767, -32768), 0, none});
        rows.push_back('{mk(-32768, -32768, -32768, 1, 32767, 32767, 32767, 4095,
                            32767, -32768, 32767), 0, none});
        rows.push_back('{mk(-32768, 32767, 0, 1, 32767, -32768, 0, 1, 0, 0, 0), 0, none});
        rows.push_back('{mk(1, 0, 0, 511, 0, 1, 0, 511, 0, 0, 0), 0, none});
        rows.push_back('{mk(0, 0, 1, 100, 0, 0, 2, 2000, 1, 1, 0), 0, none});

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) send_event(rows[i].ev, rows[i].known, rows[i].want);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_threshold(ph < 4 ? levels[ph] : 16'($urandom_range(46080)));
            for (int n = 0; n < RANDOM_ITEMS / 6; n++) begin
                quiet = (ph == 2 && n >= 50 && n < 200);
                if (ph == 1 && n == 20) hold_req = 1'b1;
                send_event(random_event($urandom_range(9) < 8), 1'b0, none);
                if (ph == 3 && n == 150) drain();
            end
            quiet = 1'b0;
            drain();
        end

        if (mismatches == 0 && verdict_queue.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/cbp_pkg.sv
rtl/cbp_angle.sv
rtl/compton_cone_backprojection_test_top.sv
verif/compton_cone_backprojection_test_top_test.sv
